>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // default sizes of the queue
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int TAG_BITS_DEF = 16;

    localparam int CMD_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_OFFER      = 3'd0,
        CMD_POLL       = 3'd1,
        CMD_PEEK       = 3'd2,
        CMD_READ_AT    = 3'd3,
        CMD_REMOVE_TAG = 3'd4,
        CMD_REMOVE_AT  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        t_cell_op op;
        logic     desc;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 16,
    parameter int IDX_W    = 4,
    parameter int INDEX    = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire spq_pkg::t_cell_ctl    i_ctl,
    input  wire logic [KEY_BITS-1:0]   i_new_key,
    input  wire logic [TAG_BITS-1:0]   i_new_tag,
    input  wire logic [IDX_W-1:0]      i_pos,
    input  wire logic [KEY_BITS-1:0]   i_left_key,
    input  wire logic [TAG_BITS-1:0]   i_left_tag,
    input  wire logic                  i_left_valid,
    input  wire logic [KEY_BITS-1:0]   i_right_key,
    input  wire logic [TAG_BITS-1:0]   i_right_tag,
    input  wire logic                  i_right_valid,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [TAG_BITS-1:0]        o_tag,
    output logic                       o_valid,
    output logic                       o_before,
    output logic                       o_match
);
    import spq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                r_valid, n_valid;
    logic                w_goes_before;
    logic                w_at_or_after;

    // new key lands ahead of this entry (empty cells always take it)
    assign w_goes_before = i_ctl.desc ? (i_new_key > r_key) : (i_new_key < r_key);
    assign o_before      = !r_valid || w_goes_before;
    assign o_match       = r_valid && (r_tag == i_new_tag);
    assign w_at_or_after = (MY_IDX >= i_pos);

    always_comb begin
        n_key   = r_key;
        n_tag   = r_tag;
        n_valid = r_valid;
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (w_at_or_after) begin
                    // the insert point takes the new entry, later cells shift right
                    if (MY_IDX == i_pos) begin
                        n_key = i_new_key;
                        n_tag = i_new_tag;
                    end else begin
                        n_key = i_left_key;
                        n_tag = i_left_tag;
                    end
                    n_valid = r_valid || i_left_valid;
                end
            end
            CELL_DELETE: begin
                if (w_at_or_after) begin
                    n_key   = i_right_key;
                    n_tag   = i_right_tag;
                    n_valid = i_right_valid;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_key   = r_key;
    assign o_tag   = r_tag;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> rtl/core/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// sorted priority queue built as a row of DEPTH cells, head in cell 0
// input channel: i_in_valid / o_in_ready carry one command item
//   (i_cmd, i_entry_key, i_entry_value, i_position)
// output channel: o_out_valid / i_out_ready carry one result item per command
//   (o_ok, o_slot, o_out_key, o_out_value, o_removed_count, o_occupancy)
// config: i_cfg_we writes i_cfg_data into the order bit (1 = largest key first);
//   write only while no command is in flight
// offer, poll, peek, read at and remove at finish in the accept cycle; the
//   result shows up in the cycle after acceptance, so one item per cycle while the receiver keeps up
// remove by tag deletes one matching entry per cycle: the result shows up once
//   no match is left and the output register is free, and the input stays closed until then,
//   the ripple of the chain shifting one position left being the limit
// the result sits in an output register, so a new command is taken while it
//   waits, as long as the receiver takes the old one in the same cycle
// a stalled receiver holds the result and blocks further commands
// reset empties the queue and selects smallest key first

module sorted_priority_queue_unit #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    parameter int IDX_W    = $clog2(DEPTH),
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [spq_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [KEY_BITS-1:0]       i_entry_key,
    input  wire logic [TAG_BITS-1:0]       i_entry_value,
    input  wire logic [IDX_W-1:0]          i_position,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_ok,
    output logic [IDX_W-1:0]               o_slot,
    output logic [KEY_BITS-1:0]            o_out_key,
    output logic [TAG_BITS-1:0]            o_out_value,
    output logic [CNT_W-1:0]               o_removed_count,
    output logic [CNT_W-1:0]               o_occupancy
);
    import spq_pkg::*;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PURGE = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic                r_desc;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TAG_BITS-1:0] r_purge_tag;
    logic [CNT_W-1:0]    r_purged, n_purged;

    logic                r_out_valid, n_out_valid;
    logic                r_ok, n_ok;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_val, n_val;
    logic [CNT_W-1:0]    r_removed, n_removed;

    // cell row
    logic [KEY_BITS-1:0] w_key    [DEPTH];
    logic [TAG_BITS-1:0] w_tag    [DEPTH];
    logic [DEPTH-1:0]    w_valid;
    logic [DEPTH-1:0]    w_before;
    logic [DEPTH-1:0]    w_match;

    t_cell_ctl           w_ctl;
    logic [IDX_W-1:0]    w_pos;
    logic [TAG_BITS-1:0] w_cell_tag;

    logic                w_out_free;
    logic                w_accept;
    logic [IDX_W-1:0]    w_ins_slot;
    logic                w_any_match;
    logic [IDX_W-1:0]    w_match_idx;
    logic                w_pos_ok;
    t_cmd                w_cmd;

    assign w_cmd      = t_cmd'(i_cmd);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pos_ok   = (CNT_W'(i_position) < r_count);

    // cells compare against the purge tag while a remove by tag runs
    assign w_cell_tag = (r_state == S_PURGE) ? r_purge_tag : i_entry_value;

    // insert position: first cell the new key goes before
    always_comb begin
        w_ins_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_before[i]) begin
                w_ins_slot = IDX_W'(i);
            end
        end
    end

    // first entry carrying the purge tag
    always_comb begin
        w_any_match = 1'b0;
        w_match_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_any_match = 1'b1;
                w_match_idx = IDX_W'(i);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_BITS-1:0] w_lkey, w_rkey;
            logic [TAG_BITS-1:0] w_ltag, w_rtag;
            logic                w_lvalid, w_rvalid;

            if (g == 0) begin : g_head
                assign w_lkey    = '0;
                assign w_ltag    = '0;
                assign w_lvalid  = 1'b1;
            end else begin : g_mid
                assign w_lkey    = w_key[g-1];
                assign w_ltag    = w_tag[g-1];
                assign w_lvalid  = w_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_rkey   = '0;
                assign w_rtag   = '0;
                assign w_rvalid = 1'b0;
            end else begin : g_body
                assign w_rkey   = w_key[g+1];
                assign w_rtag   = w_tag[g+1];
                assign w_rvalid = w_valid[g+1];
            end

            spq_cell #(
                .KEY_BITS (KEY_BITS),
                .TAG_BITS (TAG_BITS),
                .IDX_W    (IDX_W),
                .INDEX    (g)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_new_key     (i_entry_key),
                .i_new_tag     (w_cell_tag),
                .i_pos         (w_pos),
                .i_left_key    (w_lkey),
                .i_left_tag    (w_ltag),
                .i_left_valid  (w_lvalid),
                .i_right_key   (w_rkey),
                .i_right_tag   (w_rtag),
                .i_right_valid (w_rvalid),
                .o_key         (w_key[g]),
                .o_tag         (w_tag[g]),
                .o_valid       (w_valid[g]),
                .o_before      (w_before[g]),
                .o_match       (w_match[g])
            );
        end
    endgenerate

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_purged    = r_purged;
        n_out_valid = r_out_valid && !i_out_ready;
        n_ok        = r_ok;
        n_slot      = r_slot;
        n_key       = r_key;
        n_val       = r_val;
        n_removed   = r_removed;
        w_ctl.op    = CELL_HOLD;
        w_ctl.desc  = r_desc;
        w_pos       = i_position;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_ok        = 1'b0;
                    n_slot      = '0;
                    n_key       = '0;
                    n_val       = '0;
                    n_removed   = '0;
                    unique case (w_cmd)
                        CMD_OFFER: begin
                            if (r_count < FULL) begin
                                w_ctl.op = CELL_INSERT;
                                w_pos    = w_ins_slot;
                                n_ok     = 1'b1;
                                n_slot   = w_ins_slot;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        CMD_POLL, CMD_PEEK: begin
                            if (r_count != '0) begin
                                n_ok  = 1'b1;
                                n_key = w_key[0];
                                n_val = w_tag[0];
                                if (w_cmd == CMD_POLL) begin
                                    w_ctl.op = CELL_DELETE;
                                    w_pos    = '0;
                                    n_count  = r_count - 1'b1;
                                end
                            end
                        end
                        CMD_READ_AT, CMD_REMOVE_AT: begin
                            if (w_pos_ok) begin
                                n_ok  = 1'b1;
                                n_key = w_key[i_position];
                                n_val = w_tag[i_position];
                                if (w_cmd == CMD_REMOVE_AT) begin
                                    w_ctl.op = CELL_DELETE;
                                    n_count  = r_count - 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE_TAG: begin
                            // result comes out when the purge finishes
                            n_out_valid = r_out_valid && !i_out_ready;
                            n_purged    = '0;
                            n_state     = S_PURGE;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_PURGE: begin
                if (w_any_match) begin
                    w_ctl.op = CELL_DELETE;
                    w_pos    = w_match_idx;
                    n_count  = r_count - 1'b1;
                    n_purged = r_purged + 1'b1;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ok        = 1'b1;
                    n_slot      = '0;
                    n_key       = '0;
                    n_val       = '0;
                    n_removed   = r_purged;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ok      <= n_ok;
        r_slot    <= n_slot;
        r_key     <= n_key;
        r_val     <= n_val;
        r_removed <= n_removed;
        if (w_accept && (w_cmd == CMD_REMOVE_TAG)) begin
            r_purge_tag <= i_entry_value;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_desc      <= 1'b0;
            r_count     <= '0;
            r_purged    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_purged    <= n_purged;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_slot          = r_slot;
    assign o_out_key       = r_key;
    assign o_out_value     = r_val;
    assign o_removed_count = r_removed;
    assign o_occupancy     = r_count;

endmodule

`default_nettype wire

>>> sim/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

// checks the sorted priority queue against a scoreboard model kept in step with
// every accepted command item; each result item is compared field by field
// with the oldest prediction, under several sender/receiver idle mixes and
// both key orders

module sorted_priority_queue_unit_tb;

    import spq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int KEY_W        = KEY_BITS_DEF;
    localparam int TAG_W        = TAG_BITS_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_PRINTS   = 40;
    // tail wait: remove by tag runs on while matching entries remain
    localparam int TAIL_CYCLES  = DEPTH + 8;

    // command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic             ok;
        logic [3:0]       slot;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] value;
        logic [4:0]       removed;
        logic [4:0]       occupancy;
    } queue_result_t;

    // dut ports
    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [CMD_W-1:0] i_cmd;
    logic [KEY_W-1:0] i_entry_key;
    logic [TAG_W-1:0] i_entry_value;
    logic [3:0]       i_position;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_ok;
    logic [3:0]       o_slot;
    logic [KEY_W-1:0] o_out_key;
    logic [TAG_W-1:0] o_out_value;
    logic [4:0]       o_removed_count;
    logic [4:0]       o_occupancy;

    // scoreboard copy of the queue contents and the order bit
    logic [KEY_W-1:0] held_keys [DEPTH];
    logic [TAG_W-1:0] held_tags [DEPTH];
    int               held_count;
    logic             order_desc;

    queue_result_t    pending_results [$];
    queue_result_t    want;

    // idle knobs, in percent
    int send_idle_pct;
    int recv_stall_pct;

    // bookkeeping
    int mismatch_count;
    int cycle_count;
    int items_sent;
    int results_checked;
    int offers_total;
    int offers_on_full;
    int tag_removed_total;

    sorted_priority_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_entry_key     (i_entry_key),
        .i_entry_value   (i_entry_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_slot          (o_slot),
        .o_out_key       (o_out_key),
        .o_out_value     (o_out_value),
        .o_removed_count (o_removed_count),
        .o_occupancy     (o_occupancy)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // queue model
    // ---------------------------------------------------------------

    // true when a new key has to sit ahead of a key already held
    function automatic bit key_precedes(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return order_desc ? (a > b) : (a < b);
    endfunction

    // close the gap left by the entry at idx
    function automatic void drop_entry(input int idx);
        int i;
        for (i = idx; i + 1 < held_count; i++) begin
            held_keys[i] = held_keys[i + 1];
            held_tags[i] = held_tags[i + 1];
        end
        held_count--;
    endfunction

    // applies one command item to the model and returns the result it causes
    function automatic queue_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [TAG_W-1:0] tag,
                                                    input logic [3:0]       pos);
        queue_result_t r;
        int            p;
        int            i;
        r = '0;
        case (cmd)
            CMD_OFFER: begin
                offers_total++;
                if (held_count < DEPTH) begin
                    // stable: walk past every entry of equal key
                    p = 0;
                    while (p < held_count && !key_precedes(key, held_keys[p]))
                        p++;
                    for (i = held_count; i > p; i--) begin
                        held_keys[i] = held_keys[i - 1];
                        held_tags[i] = held_tags[i - 1];
                    end
                    held_keys[p] = key;
                    held_tags[p] = tag;
                    held_count++;
                    r.ok   = 1'b1;
                    r.slot = p[3:0];
                end else begin
                    offers_on_full++;
                end
            end
            CMD_POLL, CMD_PEEK: begin
                if (held_count > 0) begin
                    r.ok    = 1'b1;
                    r.key   = held_keys[0];
                    r.value = held_tags[0];
                    if (cmd == CMD_POLL)
                        drop_entry(0);
                end
            end
            CMD_READ_AT, CMD_REMOVE_AT: begin
                if (int'(pos) < held_count) begin
                    r.ok    = 1'b1;
                    r.key   = held_keys[pos];
                    r.value = held_tags[pos];
                    if (cmd == CMD_REMOVE_AT)
                        drop_entry(int'(pos));
                end
            end
            CMD_REMOVE_TAG: begin
                // compact the survivors toward the head
                p = 0;
                for (i = 0; i < held_count; i++) begin
                    if (held_tags[i] == tag) begin
                        r.removed++;
                    end else begin
                        held_keys[p] = held_keys[i];
                        held_tags[p] = held_tags[i];
                        p++;
                    end
                end
                held_count = p;
                tag_removed_total += int'(r.removed);
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.occupancy = held_count[4:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned exp_val);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at result %0d: %0s got %0d, expected %0d",
                     results_checked, field, got, exp_val);
    endtask

    // input side predicts first so a result in the same cycle as its command would still line up
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pending_results.push_back(apply_command(i_cmd, i_entry_key,
                                                        i_entry_value, i_position));
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_ok !== want.ok)
                        report_mismatch("ok", o_ok, want.ok);
                    if (o_slot !== want.slot)
                        report_mismatch("slot", o_slot, want.slot);
                    if (o_out_key !== want.key)
                        report_mismatch("out_key", o_out_key, want.key);
                    if (o_out_value !== want.value)
                        report_mismatch("out_value", o_out_value, want.value);
                    if (o_removed_count !== want.removed)
                        report_mismatch("removed_count", o_removed_count, want.removed);
                    if (o_occupancy !== want.occupancy)
                        report_mismatch("occupancy", o_occupancy, want.occupancy);
                end
                results_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("sorted_priority_queue_unit_tb: errors");
            $finish;
        end
    end

    // receiver: random stalls, new decision every falling edge
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // sends one command item; called and returns at a falling edge, valid
    // left high so back-to-back items keep it up
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag, input logic [3:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_cmd         = cmd;
        i_entry_key   = key;
        i_entry_value = tag;
        i_position    = pos;
        i_in_valid    = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // order register write, only with the block idle
    task automatic set_order(input logic desc);
        wait_for_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = desc;
        @(posedge i_clk);
        order_desc = desc;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every head/index command and a remove by tag on an empty queue, plus an unused code
    task automatic test_empty_queue();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_order(1'b0);
        send_item(CMD_POLL, 16'h0000, 16'h0000, 4'd0);
        send_item(CMD_PEEK, 16'hFFFF, 16'hFFFF, 4'd0);
        send_item(CMD_READ_AT, 16'h0000, 16'h0000, 4'd0);
        send_item(CMD_REMOVE_AT, 16'h0000, 16'h0000, 4'd15);
        send_item(CMD_REMOVE_TAG, 16'h0000, 16'hFFFF, 4'd0);
        send_item(CMD_UNUSED_7, 16'hFFFF, 16'hFFFF, 4'd15);
    endtask

    // fill to the brim with extreme and repeated keys, then overflow and
    // unload through each removal path
    task automatic test_fill_and_overflow();
        logic [KEY_W-1:0] fill_keys [DEPTH];
        int               i;
        fill_keys = '{16'd100, 16'd0, 16'hFFFF, 16'd100, 16'd100, 16'd50, 16'd0, 16'hFFFF,
                      16'd7, 16'd100, 16'd200, 16'd1, 16'hFFFE, 16'd50, 16'd100, 16'd3};
        for (i = 0; i < DEPTH; i++)
            send_item(CMD_OFFER, fill_keys[i], (i % 3 == 0) ? 16'hA5A5 : TAG_W'(i), 4'd0);
        send_item(CMD_OFFER, 16'd42, 16'h1234, 4'd0);
        send_item(CMD_READ_AT, 16'h0000, 16'h0000, 4'd15);
        send_item(CMD_REMOVE_TAG, 16'h0000, 16'hA5A5, 4'd0);
        send_item(CMD_REMOVE_AT, 16'h0000, 16'h0000, 4'd2);
        send_item(CMD_READ_AT, 16'h0000, 16'h0000, 4'd15);
        send_item(CMD_POLL, 16'h0000, 16'h0000, 4'd0);
    endtask

    // flip to largest-first with entries still held
    task automatic test_order_flip();
        set_order(1'b1);
        send_item(CMD_OFFER, 16'hFFFF, 16'h0001, 4'd0);
        send_item(CMD_OFFER, 16'h0000, 16'h0002, 4'd0);
        send_item(CMD_PEEK, 16'h0000, 16'h0000, 4'd0);
    endtask

    // random commands; fill and drain tendencies alternate so the occupancy
    // sweeps between empty and full many times
    task automatic run_random_phase(input int n_items, input int idle_pct,
                                    input int stall_pct, input logic desc);
        int               n;
        int               roll;
        bit               filling;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [3:0]       pos;
        set_order(desc);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        filling = 1'b1;
        n = 0;
        while (n < n_items) begin
            if (held_count == DEPTH && $urandom_range(1) == 0)
                filling = 1'b0;
            else if (held_count == 0)
                filling = 1'b1;
            else if ($urandom_range(29) == 0)
                filling = ~filling;

            // command mix
            if ($urandom_range(99) < (filling ? 55 : 15)) begin
                cmd = CMD_OFFER;
            end else begin
                roll = $urandom_range(99);
                if (roll < 25)      cmd = CMD_POLL;
                else if (roll < 40) cmd = CMD_PEEK;
                else if (roll < 60) cmd = CMD_READ_AT;
                else if (roll < 75) cmd = CMD_REMOVE_TAG;
                else if (roll < 97) cmd = CMD_REMOVE_AT;
                else                cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
            end

            // dense small keys give plenty of ties for the stability check
            roll = $urandom_range(9);
            if (roll < 4)       key = KEY_W'($urandom_range(7));
            else if (roll == 4) key = $urandom_range(1) ? '1 : '0;
            else                key = KEY_W'($urandom);

            // few distinct tags so removal by tag hits several entries
            roll = $urandom_range(99);
            if (cmd == CMD_REMOVE_TAG && held_count > 0 && roll < 60)
                tag = held_tags[$urandom_range(held_count - 1)];
            else if (roll < 50) tag = TAG_W'($urandom_range(3));
            else if (roll < 55) tag = '1;
            else                tag = TAG_W'($urandom);

            // mostly valid indexes, the rest anywhere in the field
            if (held_count > 0 && $urandom_range(3) != 0)
                pos = 4'($urandom_range(held_count - 1));
            else
                pos = 4'($urandom_range(15));

            send_item(cmd, key, tag, pos);
            if (cmd != CMD_UNUSED_6 && cmd != CMD_UNUSED_7)
                n++;
            // one full pause in the middle of every phase
            if (n == n_items / 2)
                wait_for_results();
        end
    endtask

    task automatic test_random_no_idle();
        run_random_phase(260, 0, 0, 1'b0);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(260, 68, 0, 1'b1);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(260, 0, 68, 1'b0);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(260, 34, 34, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        // every input known from time zero
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = 1'b0;
        i_in_valid     = 1'b0;
        i_cmd          = CMD_OFFER;
        i_entry_key    = '0;
        i_entry_value  = '0;
        i_position     = '0;
        i_out_ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        held_count     = 0;
        order_desc     = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        results_checked   = 0;
        offers_total      = 0;
        offers_on_full    = 0;
        tag_removed_total = 0;

        // synchronous reset held low, then released at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_order_flip();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        // drain, then give any stray result time to show up
        wait_for_results();
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("covered %0d command items, %0d offers (%0d on a full queue), %0d results checked",
                 items_sent, offers_total, offers_on_full, results_checked);
        $display("both key orders, four idle/stall mixes, %0d entries removed by tag match",
                 tag_removed_total);
        if (mismatch_count == 0)
            $display("sorted_priority_queue_unit_tb: clean");
        else
            $display("sorted_priority_queue_unit_tb: errors");
        $finish;
    end

endmodule
